FILE: rtl/core/grd_pkg.sv
// ============================================================================
// grd_pkg
// Shared types and constants for the Golomb-Rice decoder.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package grd_pkg;

  localparam int unsigned RiceK  = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned VbW    = 4;
  localparam int unsigned QW     = 5;
  localparam int unsigned SymW   = 8;
  localparam int unsigned MaxOut = 2;
  localparam int unsigned CntW   = $clog2(MaxOut + 1);
  localparam int unsigned RcW    = (RiceK > 1) ? $clog2(RiceK) : 1;

  typedef struct packed {
    logic [ByteW-1:0] code_byte;
    logic             is_last;
    logic [VbW-1:0]   valid_bits;
  } in_item_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [SymW-1:0] sym0;
    logic [SymW-1:0] sym1;
  } grd_bundle_t;

endpackage

`default_nettype wire

FILE: rtl/core/grd_decode.sv
// ============================================================================
// grd_decode
// Input register, code word state and single-pass decode of one byte.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module grd_decode import grd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  input  wire logic        take_i,
  output logic             bundle_valid_o,
  output grd_bundle_t      bundle_o
);

  logic              vld_q;
  in_item_t          in_q;
  logic              phase_q, phase_d;
  logic [QW-1:0]     q_q, q_d;
  logic [RiceK-1:0]  r_q, r_d;
  logic [RcW-1:0]    rc_q, rc_d;
  logic              advance;
  logic [VbW-1:0]    nbits;
  logic              bit_v;
  grd_bundle_t       bundle;

  assign advance        = vld_q && take_i;
  assign in_ready_o     = !vld_q || advance;
  assign bundle_valid_o = advance;
  assign bundle_o       = bundle;

  always_comb begin
    phase_d = phase_q;
    q_d     = q_q;
    r_d     = r_q;
    rc_d    = rc_q;
    bundle  = '0;
    bit_v   = 1'b0;
    if (in_q.is_last) begin
      nbits = (in_q.valid_bits > VbW'(ByteW)) ? VbW'(ByteW) : in_q.valid_bits;
    end else begin
      nbits = VbW'(ByteW);
    end
    for (int i = 0; i < ByteW; i++) begin
      if (VbW'(i) < nbits) begin
        bit_v = in_q.code_byte[i];
        if (phase_d) begin
          if (bit_v) begin
            q_d = q_d + 1'b1;
          end else begin
            phase_d = 1'b0;
            r_d     = '0;
            rc_d    = '0;
          end
        end else begin
          r_d = r_d | (RiceK'(bit_v) << rc_d);
          if (rc_d == RcW'(RiceK - 1)) begin
            if (bundle.cnt == CntW'(0)) begin
              bundle.sym0 = SymW'({q_d, r_d});
              bundle.cnt  = CntW'(1);
            end else if (bundle.cnt == CntW'(1)) begin
              bundle.sym1 = SymW'({q_d, r_d});
              bundle.cnt  = CntW'(2);
            end
            phase_d = 1'b1;
            q_d     = '0;
            r_d     = '0;
            rc_d    = '0;
          end else begin
            rc_d = rc_d + 1'b1;
          end
        end
      end
    end
    if (in_q.is_last) begin
      phase_d = 1'b1;
      q_d     = '0;
      r_d     = '0;
      rc_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= 1'b1;
      q_q     <= '0;
      r_q     <= '0;
      rc_q    <= '0;
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (advance) begin
        phase_q <= phase_d;
        q_q     <= q_d;
        r_q     <= r_d;
        rc_q    <= rc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/grd_out_buf.sv
// ============================================================================
// grd_out_buf
// Result register: holds up to two symbols and hands them out one a cycle while the output is ready.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module grd_out_buf import grd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        bundle_valid_i,
  input  wire grd_bundle_t bundle_i,
  output logic             take_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o
);

  logic            pend_q;
  logic            rd_q;
  logic            two_q;
  logic [SymW-1:0] sym0_q, sym1_q;
  logic            is_final;
  logic            final_taken;
  logic            load;

  assign is_final    = !two_q || rd_q;
  assign final_taken = pend_q && out_ready_i && is_final;
  assign take_o      = !pend_q || final_taken;
  assign load        = bundle_valid_i && (bundle_i.cnt != CntW'(0));

  assign out_valid_o            = pend_q;
  assign out_item_o.symbol      = rd_q ? sym1_q : sym0_q;
  assign out_item_o.last_of_run = is_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      rd_q   <= 1'b0;
      two_q  <= 1'b0;
    end else begin
      if (load) begin
        pend_q <= 1'b1;
        rd_q   <= 1'b0;
        two_q  <= (bundle_i.cnt == CntW'(2));
      end else if (final_taken) begin
        pend_q <= 1'b0;
        rd_q   <= 1'b0;
      end else if (pend_q && out_ready_i) begin
        rd_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sym0_q <= bundle_i.sym0;
      sym1_q <= bundle_i.sym1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/golomb_rice_decoder_top.sv
// ============================================================================
// golomb_rice_decoder_top
// Golomb-Rice decoder, divisor 8: one coded byte in, zero to two symbols out.
//
//   channel | dir | handshake              | payload
//   in      | in  | in_valid_i/in_ready_o  | in_item_t  (code_byte, is_last, valid_bits)
//   out     | out | out_valid_o/out_ready_i| out_item_t (symbol, last_of_run)
//
// An item is registered when taken and decoded from the input register; its
// symbols enter the result register when it is free or its last symbol goes
// out, and leave it one per cycle while out_ready_i is high. Throughput is set
// by the single output port of the result register.
// Reset clears the code word state and all valid flags.
// A stalled output holds its symbol; the input stalls while the input and
// result registers are both full and the last symbol held is not being taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module golomb_rice_decoder_top import grd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  logic        take;
  logic        bundle_valid;
  grd_bundle_t bundle;

  grd_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_item_i      (in_item_i),
    .take_i         (take),
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  grd_out_buf u_out_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bundle_valid_i (bundle_valid),
    .bundle_i       (bundle),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/grd_checker.sv
// ============================================================================
// grd_checker
// Port-level checks for the Golomb-Rice decoder, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module grd_checker import grd_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output item changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output pending");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last_of_run |=> out_valid_o)
    else $error("second symbol of a byte missing");

  a_second_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last_of_run |=> out_item_o.last_of_run)
    else $error("more than two symbols from one byte");

endmodule

bind golomb_rice_decoder_top grd_checker u_grd_checker (.*);

`default_nettype wire
